// ===== hdl/b3td_pkg.sv =====
// ---------------------------------------------------------------------------
// b3td_pkg: shared types and constants of the ternary dot-product core
// Holds the base-3 digit lookup table, the digit codes and the stage-control
// struct that passes between the top level and the merge stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b3td_pkg;

  // Lane count and fixed field widths
  localparam int LANES   = 4;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 3;
  localparam int DIGIT_W = 2;
  localparam int DOT_W   = 32;
  localparam int LUT_N   = 256;

  // Result bus: dot sum, then the clip flag, padded to whole bytes
  localparam int OUT_BITS = DOT_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Base-3 digit codes carried in the weight byte
  typedef enum logic [DIGIT_W-1:0] {
    TRIT_NEG  = 2'd0,
    TRIT_ZERO = 2'd1,
    TRIT_POS  = 2'd2
  } trit_t;

  // Four 2-bit digits per byte, lowest digit in the low bits
  typedef logic [LANES*DIGIT_W-1:0] digit_lut_t [LUT_N];

  // Builds the byte-to-digits table by enumerating digit combinations.
  // Bytes of 81 and up repeat the pattern, since only the low four digits count.
  function automatic digit_lut_t build_digit_lut();
    digit_lut_t lut;
    int v;
    lut = '{default: '0};
    for (int q = 0; q < 4; q++) begin
      for (int d3 = 0; d3 < 3; d3++) begin
        for (int d2 = 0; d2 < 3; d2++) begin
          for (int d1 = 0; d1 < 3; d1++) begin
            for (int d0 = 0; d0 < 3; d0++) begin
              v = 81 * q + 27 * d3 + 9 * d2 + 3 * d1 + d0;
              if (v < LUT_N) begin
                lut[v] = {DIGIT_W'(d3), DIGIT_W'(d2), DIGIT_W'(d1), DIGIT_W'(d0)};
              end
            end
          end
        end
      end
    end
    return lut;
  endfunction

  localparam digit_lut_t DIGIT_LUT = build_digit_lut();

  // Control of the request held between the lanes and the merge stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/b3td_lane.sv =====
// ---------------------------------------------------------------------------
// b3td_lane: one ternary weight lane
// Turns one activation and its base-3 digit into a signed term (negated,
// passed or zero) and registers it for the merge stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b3td_lane
  import b3td_pkg::*;
#(
  parameter int ACT_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic                        lane_en,
  input  wire logic [DIGIT_W-1:0]          digit,
  input  wire logic signed [ACT_WIDTH-1:0] act,
  output logic signed [ACT_WIDTH:0]        term_r
);

  logic signed [ACT_WIDTH:0] act_ext;
  logic signed [ACT_WIDTH:0] term_nxt;

  // One extra bit so that negating the most negative activation is exact
  assign act_ext = (ACT_WIDTH + 1)'(act);

  // Digit decode: 0 subtracts, 2 adds, anything else contributes nothing
  always_comb begin
    term_nxt = '0;
    if (lane_en) begin
      case (digit)
        TRIT_NEG: term_nxt = -act_ext;
        TRIT_POS: term_nxt = act_ext;
        default:  term_nxt = '0;
      endcase
    end
  end

  // Term register, loaded when the core accepts a request
  always_ff @(posedge clk) begin
    if (load) begin
      term_r <= term_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/b3td_merge.sv =====
// ---------------------------------------------------------------------------
// b3td_merge: saturating accumulator and result register
// Applies the four lane terms in lane order to the running sum, clamping
// after each one, and loads the result register on the last request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b3td_merge
  import b3td_pkg::*;
#(
  parameter int ACT_WIDTH = 16,
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire stage_ctl_t                  s1,
  input  wire logic signed [ACT_WIDTH:0]   terms [LANES],
  input  wire logic                        out_ready,
  output logic                             s1_take,
  output logic                             out_valid,
  output logic [DOT_W-1:0]                 out_sum,
  output logic                             out_sat
);

  localparam int TERM_W = ACT_WIDTH + 1;
  localparam int SUM_W  = ((ACC_WIDTH > TERM_W) ? ACC_WIDTH : TERM_W) + 1;
  localparam logic signed [SUM_W-1:0] SUM_HI =
    SUM_W'((longint'(1) << (ACC_WIDTH - 1)) - longint'(1));
  localparam logic signed [SUM_W-1:0] SUM_LO =
    SUM_W'(-(longint'(1) << (ACC_WIDTH - 1)));

  logic signed [ACC_WIDTH-1:0] running_sum_r;
  logic                        clip_r;
  logic                        out_valid_r;
  logic [DOT_W-1:0]            out_sum_r;
  logic                        out_sat_r;

  logic signed [SUM_W-1:0]     acc;
  logic                        clip_nxt;
  logic signed [ACC_WIDTH-1:0] running_sum_nxt;
  logic                        out_free;

  // Lane-ordered saturating chain; each lane sees the clamped value before it
  always_comb begin
    acc      = SUM_W'(running_sum_r);
    clip_nxt = clip_r;
    for (int i = 0; i < LANES; i++) begin
      acc = acc + SUM_W'(terms[i]);
      if (acc > SUM_HI) begin
        acc      = SUM_HI;
        clip_nxt = 1'b1;
      end else if (acc < SUM_LO) begin
        acc      = SUM_LO;
        clip_nxt = 1'b1;
      end
    end
    running_sum_nxt = ACC_WIDTH'(acc);
  end

  // A non-last request never waits; a last one needs a free result slot
  assign out_free = !out_valid_r || out_ready;
  assign s1_take  = s1.valid && (!s1.last || out_free);

  // Accumulator and result-valid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= '0;
      clip_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (s1_take) begin
        if (s1.last) begin
          running_sum_r <= '0;
          clip_r        <= 1'b0;
        end else begin
          running_sum_r <= running_sum_nxt;
          clip_r        <= clip_nxt;
        end
      end
      if (s1_take && s1.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (s1_take && s1.last) begin
      out_sum_r <= DOT_W'(acc);
      out_sat_r <= clip_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;
  assign out_sat   = out_sat_r;

endmodule

`default_nettype wire

// ===== hdl/base3_packed_ternary_dot_core.sv =====
// ---------------------------------------------------------------------------
// base3_packed_ternary_dot_core: streaming ternary-weight dot product
// Input requests carry a packed base-3 weight byte, four signed activations,
// a lane count and tlast. The core accumulates a saturating sum per vector
// and sends one result request (sum and clip flag) for each tlast request.
//
// Channels: in_* is the request side, out_* the result side. A transfer
// happens on a rising edge with tvalid and tready both high.
// Path: a last request passes the lane register, then the result register
// in the merge stage, before its result shows on out_*.
// Throughput: one request per cycle unless a last request is blocked; the
// cycle is set by the chain of four saturating adds in the merge stage.
// Reset (rst_n low, synchronous) clears the running sum, the clip flag and
// all valid flags; no result is pending afterwards.
// Stall: while a result waits on out_tready, non-last requests keep flowing
// into the accumulator; a second last request holds in the lane register,
// and in_tready drops only while that request is blocked.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base3_packed_ternary_dot_core
  import b3td_pkg::*;
#(
  parameter int ACT_WIDTH = 16,
  parameter int ACC_WIDTH = 32,
  localparam int IN_BITS  = BYTE_W + LANES * ACT_WIDTH + CNT_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Fields from bit 0 up: weight_byte, act_lane0..act_lane3, lanes_used, zero pad
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             in_tvalid,
  input  wire logic             in_tlast,
  output logic                  in_tready,
  // Fields from bit 0 up: dot_sum, saturated, zero pad
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready
);

  localparam int ACT_LO = BYTE_W;
  localparam int CNT_LO = BYTE_W + LANES * ACT_WIDTH;

  logic [BYTE_W-1:0]              weight_byte;
  logic [CNT_W-1:0]               lanes_used;
  logic [LANES*DIGIT_W-1:0]       digits;
  logic                           in_fire;
  logic                           s1_valid_r;
  logic                           s1_valid_nxt;
  logic                           s1_last_r;
  logic                           s1_take;
  stage_ctl_t                     s1_ctl;
  logic signed [ACT_WIDTH:0]      terms [LANES];
  logic                           res_valid;
  logic [DOT_W-1:0]               res_sum;
  logic                           res_sat;

  // Request field unpacking and digit lookup
  assign weight_byte = in_tdata[BYTE_W-1:0];
  assign lanes_used  = in_tdata[CNT_LO +: CNT_W];
  assign digits      = DIGIT_LUT[weight_byte];

  // The lane register frees up when the merge stage takes its request
  assign in_tready = !s1_valid_r || s1_take;
  assign in_fire   = in_tvalid && in_tready;

  // Lane stage: one term per lane, computed side by side
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    b3td_lane #(
      .ACT_WIDTH (ACT_WIDTH)
    ) u_lane (
      .clk     (clk),
      .load    (in_fire),
      .lane_en (lanes_used > CNT_W'(g)),
      .digit   (digits[g*DIGIT_W +: DIGIT_W]),
      .act     (in_tdata[ACT_LO + g*ACT_WIDTH +: ACT_WIDTH]),
      .term_r  (terms[g])
    );
  end

  // Lane-stage control
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        s1_last_r <= in_tlast;
      end
    end
  end

  assign s1_ctl.valid = s1_valid_r;
  assign s1_ctl.last  = s1_last_r;

  // Merge stage: saturating accumulation and result register
  b3td_merge #(
    .ACT_WIDTH (ACT_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1        (s1_ctl),
    .terms     (terms),
    .out_ready (out_tready),
    .s1_take   (s1_take),
    .out_valid (res_valid),
    .out_sum   (res_sum),
    .out_sat   (res_sat)
  );

  // Result packing
  assign out_tvalid = res_valid;
  assign out_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, res_sat, res_sum};

`ifndef SYNTHESIS
  // Backpressure reaches the input only through a blocked last request
  a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && s1_last_r && out_tvalid && !out_tready)
    else $error("in_tready low without a blocked last request");

  // A request that does not end a vector never waits in the lane stage
  a_nonlast_flows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_last_r |-> s1_take)
    else $error("non-last request stalled in the lane stage");

  // Taking a last request presents a result on the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && s1_last_r |=> out_tvalid)
    else $error("last request did not produce a result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_base3_packed_ternary_dot_core.sv =====
// ---------------------------------------------------------------------------
// tb_base3_packed_ternary_dot_core: self-checking bench for the ternary core
// Streams packed base-3 weight bytes with four Q8.8 activations into the
// core and predicts each vector's saturated sum and clip flag in a small
// scoreboard. A short directed set covers the digit extremes, bytes above
// 80, every lane count and back-to-back vector ends, and a random part
// follows. The sender idles in bursts and the receiver stalls in changing
// patterns. One long receiver hold-off backs the core up until it stalls
// its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_base3_packed_ternary_dot_core;
  import b3td_pkg::*;

  localparam int ACT_W        = 16;
  localparam int IN_W         = ((BYTE_W + LANES * ACT_W + CNT_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 600;

  // One input request, laid out as on in_tdata with tlast on top
  typedef struct packed {
    logic                        last;
    logic [CNT_W-1:0]            lanes;
    logic [LANES-1:0][ACT_W-1:0] act;
    logic [BYTE_W-1:0]           weight;
  } dot_request_t;

  typedef struct {
    logic [DOT_W-1:0] sum;
    logic             clip;
  } dot_result_t;

  // Predicts the sum of each vector and holds the sums still owed by the core.
  class dot_scoreboard;
    longint      acc;
    bit          clip_seen;
    dot_result_t sums_owed[$];
    int          error_count;

    function new();
      acc         = 0;
      clip_seen   = 0;
      error_count = 0;
    endfunction

    function longint clamp_sum(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (DOT_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        clip_seen = 1;
        return hi;
      end
      if (v < lo) begin
        clip_seen = 1;
        return lo;
      end
      return v;
    endfunction

    // Applies the leading lanes of an accepted request to the running sum.
    function void note_request(dot_request_t r);
      logic [BYTE_W-1:0] residue;
      trit_t             digit;
      longint            a;
      dot_result_t       res;
      residue = r.weight;
      for (int lane = 0; lane < LANES; lane++) begin
        digit   = trit_t'(2'(residue % 3));
        residue = residue / 3;
        if (lane < r.lanes) begin
          a = longint'($signed(r.act[lane]));
          case (digit)
            TRIT_NEG: acc = clamp_sum(acc - a);
            TRIT_POS: acc = clamp_sum(acc + a);
            default: ;
          endcase
        end
      end
      if (r.last) begin
        res.sum  = acc[DOT_W-1:0];
        res.clip = clip_seen;
        sums_owed.push_back(res);
        acc       = 0;
        clip_seen = 0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    // Compares one accepted result with the oldest sum owed.
    task check_result(logic [OUT_W-1:0] data);
      dot_result_t e;
      if (sums_owed.size() == 0) begin
        report($sformatf("unexpected result sum=%0d", $signed(data[DOT_W-1:0])));
        return;
      end
      e = sums_owed.pop_front();
      if (data[DOT_W-1:0] !== e.sum) begin
        report($sformatf("dot_sum got %0d, want %0d",
                         $signed(data[DOT_W-1:0]), $signed(e.sum)));
      end
      if (data[DOT_W] !== e.clip) begin
        report($sformatf("saturated got %b, want %b", data[DOT_W], e.clip));
      end
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic [IN_W-1:0] in_tdata = '0;
  logic            in_tvalid = 1'b0;
  logic            in_tlast = 1'b0;
  logic            in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic            out_tvalid;
  logic            out_tready = 1'b0;

  dot_scoreboard sb;
  int            burst_left = 0;
  int            hold_cycles = 0;
  int            cycle_count = 0;

  base3_packed_ternary_dot_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #5 clk = ~clk;

  function automatic dot_request_t make_request(logic [7:0] weight, logic [15:0] a0,
                                                logic [15:0] a1, logic [15:0] a2,
                                                logic [15:0] a3, logic [2:0] lanes,
                                                logic last);
    dot_request_t r;
    r.weight = weight;
    r.act    = {a3, a2, a1, a0};
    r.lanes  = lanes;
    r.last   = last;
    return r;
  endfunction

  // Offers one request and waits for its handshake; paced requests come in
  // bursts with idle gaps between them.
  task automatic send_request(dot_request_t r, bit paced);
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
          repeat ($urandom_range(0, 7)) @(negedge clk);
        end
      end
      burst_left--;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({r.lanes, r.act, r.weight});
    in_tlast  <= r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic send_random_vectors();
    dot_request_t r;
    int           sent;
    int           len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        r.weight = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(81, 255))
                                               : 8'($urandom_range(0, 80));
        for (int lane = 0; lane < LANES; lane++) begin
          case ($urandom_range(0, 7))
            0: r.act[lane] = 16'h7FFF;
            1: r.act[lane] = 16'h8000;
            2: r.act[lane] = 16'h0000;
            default: r.act[lane] = 16'($urandom);
          endcase
        end
        r.last = (i == len - 1);
        // Full lanes mostly; a partial count at a vector's end; odd counts as noise
        if ($urandom_range(0, 11) == 0) begin
          r.lanes = 3'($urandom_range(0, 7));
        end else if (r.last) begin
          r.lanes = 3'($urandom_range(1, 4));
        end else begin
          r.lanes = 3'd4;
        end
        send_request(r, 1'b1);
        sent++;
        if (sent == 300) begin
          hold_cycles = HOLD_CYCLES;
        end
      end
    end
  endtask

  // Receiver: ready pattern changes every stretch; a requested hold-off wins.
  initial begin
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(8, 64);
      repeat (len) begin
        @(negedge clk);
        if (hold_cycles > 0) begin
          out_tready  <= 1'b0;
          hold_cycles = hold_cycles - 1;
        end else begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_base3_packed_ternary_dot_core failed");
    $finish;
  end

  // Main sequence
  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Digit extremes, bytes above 80 and every lane count
    send_request(make_request(8'd80, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd4, 1'b1), 1'b1);
    send_request(make_request(8'd0, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 3'd4, 1'b1), 1'b1);
    send_request(make_request(8'd40, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 3'd4, 1'b1), 1'b1);
    send_request(make_request(8'd255, 16'h1234, 16'h4321, 16'h0100, 16'hFF00, 3'd4, 1'b1), 1'b1);
    send_request(make_request(8'd81, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 3'd4, 1'b0), 1'b1);
    send_request(make_request(8'd162, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 3'd4, 1'b0), 1'b1);
    send_request(make_request(8'd243, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE, 3'd4, 1'b1), 1'b1);
    send_request(make_request(8'd80, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0, 1'b1), 1'b1);
    send_request(make_request(8'd80, 16'h0011, 16'h0022, 16'h0033, 16'h0044, 3'd1, 1'b0), 1'b1);
    send_request(make_request(8'd80, 16'h0011, 16'h0022, 16'h0033, 16'h0044, 3'd2, 1'b0), 1'b1);
    send_request(make_request(8'd80, 16'h0011, 16'h0022, 16'h0033, 16'h0044, 3'd3, 1'b1), 1'b1);
    send_request(make_request(8'd80, 16'h1000, 16'h2000, 16'h3000, 16'h4000, 3'd5, 1'b0), 1'b1);
    send_request(make_request(8'd0, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 3'd7, 1'b1), 1'b1);
    send_request(make_request(8'd5, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'd4, 1'b0), 1'b1);
    send_request(make_request(8'd60, 16'h0F0F, 16'hF0F0, 16'h8000, 16'h7FFF, 3'd4, 1'b0), 1'b1);
    send_request(make_request(8'd80, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd0, 1'b1), 1'b1);
    send_request(make_request(8'd6, 16'hC000, 16'h4000, 16'h0000, 16'hFFFF, 3'd6, 1'b1), 1'b1);

    send_random_vectors();

    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (sb.sums_owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.error_count == 0) begin
      $display("tb_base3_packed_ternary_dot_core passed");
    end else begin
      $display("tb_base3_packed_ternary_dot_core failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/b3td_pkg.sv
hdl/b3td_lane.sv
hdl/b3td_merge.sv
hdl/base3_packed_ternary_dot_core.sv
tb/sv/tb_base3_packed_ternary_dot_core.sv
